@@ rtl/wbee_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbee_pkg
// Shared constants, codes and controller/datapath bundles for the windowed
// binary entropy estimator.
// ----------------------------------------------------------------------------
package wbee_pkg;

  localparam int MaxWin   = 32;
  localparam int IdxW     = $clog2(MaxWin);
  localparam int WdoneW   = IdxW + 1;
  localparam int CntW     = 20;
  localparam int FracW    = 16;
  localparam int LogFrac  = 24;
  localparam int NormFrac = 30;
  localparam int ExpW     = 5;
  localparam int LogW     = ExpW + LogFrac;
  localparam int ProdW    = CntW + LogW;
  localparam int DvdW     = ProdW + 1;
  localparam int DvsW     = 27;
  localparam int CfgW     = 13;
  localparam int PosW     = 12;
  localparam int OnesW    = 13;
  localparam int SumW     = 21;
  localparam int SqsW     = 37;
  localparam int VarW     = 15;
  localparam int WinMax   = 4096;
  localparam int CfgReset = 64;

  typedef enum logic [1:0] {
    LOG_SEL_W = 2'd0,
    LOG_SEL_N = 2'd1,
    LOG_SEL_M = 2'd2
  } log_sel_e;

  typedef enum logic [1:0] {
    DIV_ENT  = 2'd0,
    DIV_MEAN = 2'd1,
    DIV_VAR  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic            accept;
    logic            ent_ld_rec;
    logic            ent_zero;
    logic            ent_fin;
    logic            log_start;
    log_sel_e        log_sel;
    logic            mul;
    logic            div_start;
    div_sel_e        div_sel;
    logic            store;
    logic            mean_latch;
    logic            var_latch;
    logic            rd_issue;
    logic            out_load;
    logic            out_rec;
    logic [IdxW-1:0] idx;
    logic            clear_rec;
  } cmd_t;

  typedef struct packed {
    logic closed;
    logic last;
    logic ent_trivial;
    logic log_done;
    logic div_done;
    logic out_fire;
    logic rd_last;
    logic have_windows;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/wbee_log2.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbee_log2
// Iterative log2: integer part from the leading one, fraction by repeated
// squaring of the normalized value, one fraction bit per cycle.
// ----------------------------------------------------------------------------
module wbee_log2
  import wbee_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [CntW-1:0] x_i,
  output logic                 done_o,
  output logic [LogW-1:0]      log_o
);

  logic [NormFrac:0]     y_q, y_d;
  logic [LogFrac-1:0]    frac_q, frac_d;
  logic [ExpW-1:0]       e_q, e_d, msb;
  logic [ExpW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [2*NormFrac+1:0] sq;
  logic [NormFrac+1:0]   t;

  always_comb begin
    msb = '0;
    for (int i = 0; i < CntW; i++) begin
      if (x_i[i]) msb = ExpW'(i);
    end
  end

  assign sq = y_q * y_q;
  assign t  = sq[2*NormFrac+1:NormFrac];

  always_comb begin
    y_d    = y_q;
    frac_d = frac_q;
    e_d    = e_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      e_d    = msb;
      y_d    = (NormFrac+1)'(x_i) << (ExpW'(NormFrac) - msb);
      frac_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (t[NormFrac+1]) begin
        y_d    = t[NormFrac+1:1];
        frac_d = {frac_q[LogFrac-2:0], 1'b1};
      end else begin
        y_d    = t[NormFrac:0];
        frac_d = {frac_q[LogFrac-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ExpW'(LogFrac - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    frac_q <= frac_d;
    e_q    <= e_d;
  end

  assign done_o = done_q;
  assign log_o  = {e_q, frac_q};

endmodule
`default_nettype wire

@@ rtl/wbee_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbee_div
// Restoring divider, one quotient bit per cycle; shared by the entropy,
// mean and variance steps.
// ----------------------------------------------------------------------------
module wbee_div
  import wbee_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dvd_i,
  input  wire logic [DvsW-1:0] dvs_i,
  output logic                 done_o,
  output logic [DvdW-1:0]      quot_o
);

  localparam int StepW = $clog2(DvdW);

  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [DvsW:0]    rem_q, rem_d, rem_sh;
  logic [DvsW-1:0]  dvs_q, dvs_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             ge;

  assign rem_sh = {rem_q[DvsW-1:0], dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dvd_i;
      dvs_d  = dvs_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      dvd_d = {dvd_q[DvdW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

@@ rtl/wbee_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbee_datapath
// Window and record counters, entropy store, log/divide units, statistics
// and the output register.
// ----------------------------------------------------------------------------
module wbee_datapath
  import wbee_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            bit_i,
  input  wire logic            last_i,
  input  wire cmd_t            cmd_i,
  output sts_t                 sts_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output logic [55:0]          out_data_o,
  output logic [1:0]           out_user_o,
  output logic                 out_last_o
);

  logic [CfgW-1:0]   cfg_q, w_eff;
  logic [PosW-1:0]   pos_q;
  logic [OnesW-1:0]  ones_q, ones_nx;
  logic [PosW:0]     pos_nx;
  logic              closed_now;
  logic [CntW-1:0]   rbits_q, rones_q;
  logic [WdoneW-1:0] wdone_q;
  logic [SumW-1:0]   sum_q;
  logic [SqsW-1:0]   sqs_q;
  logic              ovf_q, closed_q, last_q;
  logic [CntW-1:0]   ent_n_q, ent_w_q, ent_m, log_x;
  logic [ProdW-1:0]  whole_q, prod;
  logic [DvdW-1:0]   parts_q;
  logic [15:0]       h_q, mean_q, rd_q;
  logic [VarW-1:0]   var_q;
  logic [31:0]       hsq;
  logic [SqsW+WdoneW-1:0] cs2_q;
  logic [2*SumW-1:0] ss_q;
  logic [15:0]       store_mem [MaxWin];
  logic              log_start, log_done, div_done;
  logic [LogW-1:0]   log_val;
  logic [DvdW-1:0]   dvd, quot;
  logic [DvsW-1:0]   dvs, den;
  logic [SqsW+WdoneW-1:0] num;
  logic [DvdW:0]     rnd;
  logic              rd_last;
  logic              ov_q;
  logic [55:0]       od_q;
  logic [1:0]        ou_q;
  logic              ol_q;

  assign w_eff = (cfg_q == '0) ? CfgW'(1) :
                 (cfg_q > CfgW'(WinMax)) ? CfgW'(WinMax) : cfg_q;
  assign pos_nx     = {1'b0, pos_q} + 1'b1;
  assign ones_nx    = ones_q + OnesW'(bit_i);
  assign closed_now = pos_nx >= w_eff;

  assign ent_m = ent_w_q - ent_n_q;
  always_comb begin
    case (cmd_i.log_sel)
      LOG_SEL_N: log_x = ent_n_q;
      LOG_SEL_M: log_x = ent_m;
      default:   log_x = ent_w_q;
    endcase
  end
  assign log_start = cmd_i.log_start;
  assign prod      = log_x * log_val;

  wbee_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_val)
  );

  // variance terms: c*S2 - S*S over c*c*2^16, rounded half up
  assign den = {11'(wdone_q * wdone_q), 16'b0};
  assign num = cs2_q - (SqsW+WdoneW)'(ss_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        dvd = DvdW'(sum_q) + DvdW'(wdone_q >> 1);
        dvs = DvsW'(wdone_q);
      end
      DIV_VAR: begin
        dvd = DvdW'(num) + DvdW'(den >> 1);
        dvs = den;
      end
      default: begin
        dvd = (DvdW'(whole_q) > parts_q) ? DvdW'(whole_q) - parts_q : '0;
        dvs = DvsW'(ent_w_q);
      end
    endcase
  end

  wbee_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (dvd),
    .dvs_i   (dvs),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign rnd = {1'b0, quot} + (DvdW+1)'(1 << (LogFrac - FracW - 1));
  assign hsq = h_q * h_q;
  assign rd_last = ({1'b0, cmd_i.idx} + 1'b1) == wdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CfgW'(CfgReset);
      pos_q    <= '0;
      ones_q   <= '0;
      rbits_q  <= '0;
      rones_q  <= '0;
      wdone_q  <= '0;
      sum_q    <= '0;
      sqs_q    <= '0;
      ovf_q    <= 1'b0;
      closed_q <= 1'b0;
      last_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        if (rbits_q != '1) rbits_q <= rbits_q + 1'b1;
        if (bit_i && rones_q != '1) rones_q <= rones_q + 1'b1;
        closed_q <= closed_now;
        last_q   <= last_i;
        if (closed_now) begin
          pos_q  <= '0;
          ones_q <= '0;
        end else begin
          pos_q  <= pos_nx[PosW-1:0];
          ones_q <= ones_nx;
        end
      end
      if (cmd_i.store) begin
        if (wdone_q < WdoneW'(MaxWin)) begin
          wdone_q <= wdone_q + 1'b1;
          sum_q   <= sum_q + SumW'(h_q);
          sqs_q   <= sqs_q + SqsW'(hsq);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clear_rec) begin
        pos_q   <= '0;
        ones_q  <= '0;
        rbits_q <= '0;
        rones_q <= '0;
        wdone_q <= '0;
        sum_q   <= '0;
        sqs_q   <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && closed_now) begin
      ent_n_q <= CntW'(ones_nx);
      ent_w_q <= CntW'(w_eff);
    end else if (cmd_i.ent_ld_rec) begin
      ent_n_q <= rones_q;
      ent_w_q <= rbits_q;
    end
    if (cmd_i.mul) begin
      case (cmd_i.log_sel)
        LOG_SEL_W: whole_q <= prod;
        LOG_SEL_N: parts_q <= DvdW'(prod);
        default:   parts_q <= parts_q + DvdW'(prod);
      endcase
    end
    if (cmd_i.ent_zero) h_q <= '0;
    else if (cmd_i.ent_fin) begin
      h_q <= (rnd[DvdW:LogFrac-FracW] > (DvdW+1-LogFrac+FracW)'(16'hFFFF)) ?
             16'hFFFF : rnd[LogFrac-FracW+15:LogFrac-FracW];
    end
    if (cmd_i.store && wdone_q < WdoneW'(MaxWin)) store_mem[wdone_q[IdxW-1:0]] <= h_q;
    if (cmd_i.rd_issue) rd_q <= store_mem[cmd_i.idx];
    if (cmd_i.mean_latch) begin
      mean_q <= quot[15:0];
      cs2_q  <= (SqsW+WdoneW)'(wdone_q) * (SqsW+WdoneW)'(sqs_q);
      ss_q   <= (2*SumW)'(sum_q) * (2*SumW)'(sum_q);
    end
    if (cmd_i.var_latch) var_q <= quot[VarW-1:0];
    if (cmd_i.out_load) begin
      if (cmd_i.out_rec) begin
        od_q <= {4'b0, VarW'(0), h_q, IdxW'(0), h_q};
        ou_q <= {ovf_q, 1'b1};
        ol_q <= 1'b1;
      end else begin
        od_q <= {4'b0, rd_last ? var_q : VarW'(0), rd_last ? mean_q : 16'b0,
                 cmd_i.idx, rd_q};
        ou_q <= {ovf_q, 1'b0};
        ol_q <= rd_last;
      end
    end
  end

  assign sts_o.closed       = closed_q;
  assign sts_o.last         = last_q;
  assign sts_o.ent_trivial  = (ent_n_q == '0) || (ent_n_q >= ent_w_q);
  assign sts_o.log_done     = log_done;
  assign sts_o.div_done     = div_done;
  assign sts_o.out_fire     = ov_q && out_ready_i;
  assign sts_o.rd_last      = rd_last;
  assign sts_o.have_windows = wdone_q != '0;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_user_o  = ou_q;
  assign out_last_o  = ol_q;

endmodule
`default_nettype wire

@@ rtl/wbee_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbee_ctrl
// Sequencer: takes bits, runs the entropy, statistics and result phases.
// ----------------------------------------------------------------------------
module wbee_ctrl
  import wbee_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_CHECK  = 17'h00002,
    ST_ECHK   = 17'h00004,
    ST_LSTART = 17'h00008,
    ST_LWAIT  = 17'h00010,
    ST_MUL    = 17'h00020,
    ST_DSTART = 17'h00040,
    ST_DWAIT  = 17'h00080,
    ST_STORE  = 17'h00100,
    ST_LAST   = 17'h00200,
    ST_MSTART = 17'h00400,
    ST_MWAIT  = 17'h00800,
    ST_VSTART = 17'h01000,
    ST_VWAIT  = 17'h02000,
    ST_RD     = 17'h04000,
    ST_OUT    = 17'h08000,
    ST_OWAIT  = 17'h10000
  } state_e;

  state_e          st_q, st_d;
  log_sel_e        ph_q, ph_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            rec_q, rec_d;

  always_comb begin
    st_d  = st_q;
    ph_d  = ph_q;
    idx_d = idx_q;
    rec_d = rec_q;
    cmd_o = '0;
    cmd_o.log_sel = ph_q;
    cmd_o.div_sel = DIV_ENT;
    cmd_o.idx     = idx_q;
    cmd_o.out_rec = rec_q;
    unique case (st_q)
      ST_IDLE: begin
        rec_d = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          st_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.closed) st_d = ST_ECHK;
        else if (sts_i.last) st_d = ST_LAST;
        else st_d = ST_IDLE;
      end
      ST_ECHK: begin
        if (sts_i.ent_trivial) begin
          cmd_o.ent_zero = 1'b1;
          st_d = rec_q ? ST_OUT : ST_STORE;
        end else begin
          ph_d = LOG_SEL_W;
          st_d = ST_LSTART;
        end
      end
      ST_LSTART: begin
        cmd_o.log_start = 1'b1;
        st_d = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (sts_i.log_done) st_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        unique case (ph_q)
          LOG_SEL_W: begin
            ph_d = LOG_SEL_N;
            st_d = ST_LSTART;
          end
          LOG_SEL_N: begin
            ph_d = LOG_SEL_M;
            st_d = ST_LSTART;
          end
          default: st_d = ST_DSTART;
        endcase
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        st_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ent_fin = 1'b1;
          st_d = rec_q ? ST_OUT : ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        st_d = sts_i.last ? ST_LAST : ST_IDLE;
      end
      ST_LAST: begin
        if (sts_i.closed && sts_i.have_windows) begin
          st_d = ST_MSTART;
        end else begin
          cmd_o.ent_ld_rec = 1'b1;
          rec_d = 1'b1;
          st_d  = ST_ECHK;
        end
      end
      ST_MSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_MEAN;
        st_d = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.mean_latch = 1'b1;
          st_d = ST_VSTART;
        end
      end
      ST_VSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_VAR;
        st_d = ST_VWAIT;
      end
      ST_VWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.var_latch = 1'b1;
          idx_d = '0;
          st_d  = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        st_d = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.out_load = 1'b1;
        st_d = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (sts_i.out_fire) begin
          if (rec_q || sts_i.rd_last) begin
            cmd_o.clear_rec = 1'b1;
            st_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            st_d  = ST_RD;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      ph_q  <= LOG_SEL_W;
      idx_q <= '0;
      rec_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      idx_q <= idx_d;
      rec_q <= rec_d;
    end
  end

  assign in_ready_o = st_q == ST_IDLE;

endmodule
`default_nettype wire

@@ rtl/windowed_binary_entropy_estimator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_binary_entropy_estimator_top
// Per-window binary entropy of a bit record, with mean and variance.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one record bit per beat in tdata[0], tlast on the final bit.
//   m_axis: one result per beat; tlast marks the final result of a record.
//   cfg_we_i/cfg_wdata_i: window size (0 acts as 1, above 4096 as 4096);
//   write only while idle.
// Flow:
//   A bit that closes no window needs no arithmetic. A bit that closes a flat
//   window skips log2 and divide; any other window-closing bit runs
//   three log2 steps (start, 24 squarings, done, multiply) on the
//   shared log unit and a pass through the shared divider.
//   On the final bit, mean and variance take two more divider passes,
//   then each stored window goes out as one beat, held through any stall.
//   If the record is not a multiple of the window, the whole-record entropy
//   is computed after the final bit, then its one beat goes out.
// Reset: all record state cleared, window size 64. No bit is taken while a
// result is pending; a stalled m_axis holds the current beat.
// ----------------------------------------------------------------------------
module windowed_binary_entropy_estimator_top
  import wbee_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [7:0]      s_axis_tdata,  // [0] bit_value, [7:1] zero
  input  wire logic            s_axis_tlast,  // record_end
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // [15:0] entropy, [20:16] window_number, [36:21] entropy_mean,
  // [51:37] entropy_variance, [55:52] zero
  output logic [55:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,  // [0] not_multiple_warning, [1] window_overflow
  output logic                 m_axis_tlast   // final_result
);

  cmd_t cmd;
  sts_t sts;

  wbee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbee_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bit_i       (s_axis_tdata[0]),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the windowed binary entropy estimator. It sends records of
// bits under several window sizes, predicts the per-window entropies and the
// final mean/variance, and compares every m_axis beat in order.
// ----------------------------------------------------------------------------
module tb;
  import wbee_pkg::*;

  typedef struct {
    logic [15:0] entropy;
    logic [4:0]  window_number;
    logic [15:0] mean;
    logic [14:0] variance;
    logic        warn;
    logic        overflow;
    logic        final_beat;
  } ent_result_t;

  class entropy_tracker;
    ent_result_t       expected_results[$];
    int                mismatches;
    logic [CfgW-1:0]   window_reg;
    logic [OnesW-1:0]  ones_win;
    logic [PosW:0]     pos_win;
    longint unsigned   bit_cnt, ones_cnt, ent_sum, sq_sum;
    int unsigned       win_done;
    logic [15:0]       ent_store[MaxWin];
    logic              ovf_seen;

    function new();
      mismatches = 0;
      window_reg = CfgReset;
      clear_record();
    endfunction

    function void clear_record();
      ones_win = 0; pos_win = 0; bit_cnt = 0; ones_cnt = 0;
      ent_sum = 0; sq_sum = 0; win_done = 0; ovf_seen = 0;
    endfunction

    function void set_window(logic [CfgW-1:0] v);
      window_reg = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // log2 with 24 fraction bits, by repeated squaring in Q1.30
    function longint unsigned log2_q24(longint unsigned x);
      int unsigned     e;
      longint unsigned y, frac;
      int              i;
      e = 0;
      frac = 0;
      if (x == 0) return 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      y = (e <= NormFrac) ? x << (NormFrac - e) : x >> (e - NormFrac);
      for (i = 0; i < LogFrac; i++) begin
        y = (y * y) >> NormFrac;
        frac = frac << 1;
        if (y >= (64'd2 << NormFrac)) begin
          y = y >> 1;
          frac = frac | 1;
        end
      end
      return (longint'(e) << LogFrac) | frac;
    endfunction

    function longint unsigned bin_entropy(longint unsigned n, longint unsigned w);
      longint unsigned m, whole, parts, d, q;
      if (w == 0 || n == 0 || n >= w) return 0;
      m = w - n;
      whole = w * log2_q24(w);
      parts = n * log2_q24(n) + m * log2_q24(m);
      d = (whole > parts) ? whole - parts : 0;
      q = d / w;
      q = (q + (64'd1 << (LogFrac - FracW - 1))) >> (LogFrac - FracW);
      return (q > 65535) ? 65535 : q;
    endfunction

    function void push(longint unsigned ent, int unsigned num, longint unsigned mean,
                       longint unsigned var_q, logic warn, logic fin);
      ent_result_t r;
      r.entropy = ent[15:0];
      r.window_number = num[4:0];
      r.mean = mean[15:0];
      r.variance = var_q[14:0];
      r.warn = warn;
      r.overflow = ovf_seen;
      r.final_beat = fin;
      expected_results.push_back(r);
    endfunction

    function void take_bit(logic b, logic last);
      longint unsigned w, h, c, mean, num, den, var_q;
      logic            closed;
      int unsigned     i;
      w = window_reg;
      closed = 0;
      if (w == 0) w = 1;
      if (w > WinMax) w = WinMax;
      if (bit_cnt < (64'd1 << CntW) - 1) bit_cnt++;
      if (b && ones_cnt < (64'd1 << CntW) - 1) ones_cnt++;
      if (b) ones_win = ones_win + 1;
      pos_win = pos_win + 1;
      if (pos_win >= w) begin
        h = bin_entropy(ones_win, w);
        if (win_done < MaxWin) begin
          ent_store[win_done] = h[15:0];
          win_done++;
          ent_sum += h;
          sq_sum += h * h;
        end else begin
          ovf_seen = 1;
        end
        ones_win = 0;
        pos_win = 0;
        closed = 1;
      end
      pos_win[PosW] = 1'b0;
      if (!last) return;
      if (closed && win_done > 0) begin
        c = win_done;
        mean = (ent_sum + c / 2) / c;
        num = c * sq_sum - ent_sum * ent_sum;
        den = c * c * (64'd1 << FracW);
        var_q = (num + den / 2) / den;
        for (i = 0; i < win_done; i++) begin
          if (i + 1 == win_done) push(ent_store[i], i, mean, var_q, 0, 1);
          else push(ent_store[i], i, 0, 0, 0, 0);
        end
      end else begin
        h = bin_entropy(ones_cnt, bit_cnt);
        push(h, 0, h, 0, 1, 1);
      end
      clear_record();
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_result(logic [55:0] data, logic [1:0] user, logic last);
      ent_result_t r;
      if (expected_results.size() == 0) begin
        report("unexpected beat", data, 0);
        return;
      end
      r = expected_results.pop_front();
      if (data[15:0] !== r.entropy) report("entropy", data[15:0], r.entropy);
      if (data[20:16] !== r.window_number)
        report("window_number", data[20:16], r.window_number);
      if (data[36:21] !== r.mean) report("entropy_mean", data[36:21], r.mean);
      if (data[51:37] !== r.variance)
        report("entropy_variance", data[51:37], r.variance);
      if (user[0] !== r.warn) report("not_multiple_warning", user[0], r.warn);
      if (user[1] !== r.overflow) report("window_overflow", user[1], r.overflow);
      if (last !== r.final_beat) report("final_result", last, r.final_beat);
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata = '0;   // [0] bit_value
  logic            s_axis_tlast = 1'b0; // record_end
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [55:0]     m_axis_tdata;        // entropy, window_number, mean, variance
  logic [1:0]      m_axis_tuser;        // [0] warning, [1] overflow
  logic            m_axis_tlast;        // final_result

  entropy_tracker tracker = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int bits_sent = 0;

  always #6 clk_i = ~clk_i;

  windowed_binary_entropy_estimator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // result side: check accepted beats, then pick next tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task send_bit(logic b, logic last);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, b};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_bit(b, last);
    bits_sent++;
  endtask

  task stop_sending();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
  endtask

  // density in percent of ones; 0 and 100 give flat windows
  task send_record(int len, int density);
    int i;
    for (i = 0; i < len; i++)
      send_bit($urandom_range(99) < density, i == len - 1);
  endtask

  task wait_drained();
    stop_sending();
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task write_window(logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_window(v);
  endtask

  function int pick_density();
    case ($urandom_range(5))
      0: return 0;
      1: return 100;
      default: return $urandom_range(5, 95);
    endcase
  endfunction

  initial begin
    int phase, w, len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: flat windows, a full-entropy window, not-multiple record
    write_window(4);
    send_record(8, 100);
    send_bit(1, 0); send_bit(0, 0); send_bit(1, 0); send_bit(0, 1);
    send_record(5, 50);
    wait_drained();
    write_window(0);
    send_record(3, 50);
    wait_drained();
    write_window(8191);
    send_bit(0, 0); send_bit(1, 0); send_bit(1, 1);
    wait_drained();
    write_window(4096);
    send_bit(1, 0); send_bit(0, 1);
    wait_drained();
    // window shrinks in the middle of a window
    write_window(8);
    send_bit(1, 0); send_bit(1, 0); send_bit(0, 0); send_bit(1, 0);
    wait_drained();
    write_window(2);
    send_bit(0, 1);
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 38 : (phase == 1) ? 68 : 0;
      recv_idle = (phase == 0) ? 68 : (phase == 1) ? 38 : 0;
      if (phase == 0) begin
        // one record with more windows than the store holds
        write_window(1);
        send_record($urandom_range(33, 36), pick_density());
        wait_drained();
      end
      w = (phase == 2) ? $urandom_range(9, 12) : $urandom_range(2, 8);
      write_window(w);
      if (phase == 2) begin
        @(negedge clk_i);
        hold_left = 400;
      end
      while (bits_sent < 45 + 40 * (phase + 1)) begin
        if (phase == 1 && $urandom_range(3) == 0) begin
          stop_sending();
          while (tracker.pending() != 0) @(posedge clk_i);
        end
        if ($urandom_range(3) == 0) len = $urandom_range(1, 2 * w);
        else len = w * $urandom_range(1, 3);
        send_record(len, pick_density());
      end
      wait_drained();
    end

    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wbee_pkg.sv
rtl/wbee_log2.sv
rtl/wbee_div.sv
rtl/wbee_datapath.sv
rtl/wbee_ctrl.sv
rtl/windowed_binary_entropy_estimator_top.sv
verif/tb.sv
